// ===== design/stle_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite tile list expander package
// Field positions, widths and screen constants shared by the expander.
// ----------------------------------------------------------------------------
package stle_pkg;

    localparam int S_TDATA_W = 48;   // attr, code, pos words
    localparam int M_TDATA_W = 40;   // 39 bits of placement, one pad bit
    localparam int WORD_W    = 16;
    localparam int CODE_W    = 13;
    localparam int COORD_W   = 10;
    localparam int COLOR_W   = 4;
    localparam int SPAN_W    = 3;    // tile index within one axis, 0..7

    // attribute word
    localparam int ATTR_EN_BIT  = 15;
    localparam int ATTR_FY_BIT  = 14;
    localparam int ATTR_FX_BIT  = 13;
    localparam int ATTR_LH_LSB  = 11;
    localparam int ATTR_LW_LSB  = 9;

    // position word
    localparam int POS_COLOR_LSB = 12;
    localparam int POS_FLASH_BIT = 11;

    localparam int POSN_W    = 9;
    localparam int TILE_PIX  = 16;
    localparam int X_MIRROR  = 240;
    localparam int Y_MIRROR  = 232;

    // log2 tile count to count minus one: 0,1,3,7
    function automatic logic [SPAN_W-1:0] span_m1(input logic [1:0] lg);
        span_m1 = SPAN_W'((4'd1 << lg) - 4'd1);
    endfunction

    // fold a 9-bit position into signed 10 bits (256..511 -> -256..-1)
    function automatic logic [COORD_W-1:0] fold_pos(input logic [POSN_W-1:0] p);
        fold_pos = {p[POSN_W-1], p};
    endfunction

endpackage

// ===== design/sprite_tile_list_expander_top.sv =====
// ----------------------------------------------------------------------------
// Sprite tile list expander
// Throughput: one placement per cycle unless the output stalls; the input is not
// ready while an entry of W x H tiles (up to 64) is expanded, and a shared 10-bit
// coordinate adder and the code stepper advance one placement per cycle.
// Suppressed entries are accepted and dropped without leaving idle.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module sprite_tile_list_expander_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // attr_word[15:0], code_word[31:16], pos_word[47:32]
    input  logic [stle_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // odd_frame[0]
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tile_code[12:0], tile_x[22:13], tile_y[32:23], tile_color[36:33],
    // mirror_x[37], mirror_y[38], zero pad[39]
    output logic [stle_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    localparam int CW = stle_pkg::CODE_W;
    localparam int XW = stle_pkg::COORD_W;
    localparam int SW = stle_pkg::SPAN_W;

    state_t          state_reg,   state_next;
    logic [SW-1:0]   row_reg,     row_next;
    logic [SW-1:0]   col_reg,     col_next;
    logic [SW-1:0]   rows_m1_reg, rows_m1_next;
    logic [SW-1:0]   cols_m1_reg, cols_m1_next;
    logic [XW-1:0]   x_reg,       x_next;
    logic [XW-1:0]   y_reg,       y_next;
    logic [XW-1:0]   y0_reg,      y0_next;
    logic [CW-1:0]   code_reg,    code_next;
    logic [CW-1:0]   code0_reg,   code0_next;
    logic [stle_pkg::COLOR_W-1:0] color_reg, color_next;
    logic            fx_reg,      fx_next;
    logic            fy_reg,      fy_next;

    logic            mvalid_reg,  mvalid_next;
    logic [CW-1:0]   ocode_reg,   ocode_next;
    logic [XW-1:0]   ox_reg,      ox_next;
    logic [XW-1:0]   oy_reg,      oy_next;
    logic [stle_pkg::COLOR_W-1:0] ocolor_reg, ocolor_next;
    logic            omx_reg,     omx_next;
    logic            omy_reg,     omy_next;
    logic            olast_reg,   olast_next;

    logic [stle_pkg::WORD_W-1:0] attr_w, code_w, pos_w;
    logic            accept, emit_now, slot_free, row_end, col_end, show;
    logic [XW-1:0]   step_src, step_sum;
    logic [CW-1:0]   code_step, base_code, new_rows_ext;
    logic [SW-1:0]   new_rows_m1;

    assign attr_w = s_axis_tdata[15:0];
    assign code_w = s_axis_tdata[31:16];
    assign pos_w  = s_axis_tdata[47:32];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !mvalid_reg || m_axis_tready;
    assign emit_now      = (state_reg == ST_RUN) && slot_free;
    assign row_end       = (row_reg == rows_m1_reg);
    assign col_end       = (col_reg == cols_m1_reg);

    // drop disabled entries and flashing ones on even frames
    assign show = attr_w[stle_pkg::ATTR_EN_BIT]
                  && !(pos_w[stle_pkg::POS_FLASH_BIT] && !s_axis_tuser);

    // shared coordinate adder: next column x at row end, else next row y
    assign step_src = row_end ? x_reg : y_reg;
    assign step_sum = step_src - XW'(stle_pkg::TILE_PIX);

    assign code_step = fy_reg ? (code_reg + CW'(1)) : (code_reg - CW'(1));

    assign new_rows_m1  = stle_pkg::span_m1(attr_w[stle_pkg::ATTR_LH_LSB +: 2]);
    assign new_rows_ext = CW'(new_rows_m1);
    assign base_code    = code_w[CW-1:0] & ~new_rows_ext;

    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        rows_m1_next = rows_m1_reg;
        cols_m1_next = cols_m1_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        y0_next      = y0_reg;
        code_next    = code_reg;
        code0_next   = code0_reg;
        color_next   = color_reg;
        fx_next      = fx_reg;
        fy_next      = fy_reg;
        mvalid_next  = mvalid_reg;
        ocode_next   = ocode_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        ocolor_next  = ocolor_reg;
        omx_next     = omx_reg;
        omy_next     = omy_reg;
        olast_next   = olast_reg;

        if (m_axis_tready)
        begin
            mvalid_next = 1'b0;
        end

        if (accept && show)
        begin
            state_next   = ST_RUN;
            row_next     = '0;
            col_next     = '0;
            rows_m1_next = new_rows_m1;
            cols_m1_next = stle_pkg::span_m1(attr_w[stle_pkg::ATTR_LW_LSB +: 2]);
            x_next       = XW'(stle_pkg::X_MIRROR)
                           - stle_pkg::fold_pos(pos_w[stle_pkg::POSN_W-1:0]);
            y_next       = XW'(stle_pkg::Y_MIRROR)
                           - stle_pkg::fold_pos(attr_w[stle_pkg::POSN_W-1:0]);
            y0_next      = y_next;
            fy_next      = attr_w[stle_pkg::ATTR_FY_BIT];
            fx_next      = attr_w[stle_pkg::ATTR_FX_BIT];
            color_next   = pos_w[stle_pkg::POS_COLOR_LSB +: stle_pkg::COLOR_W];
            // flipped in y counts up from the aligned base, else down from its top
            code_next    = fy_next ? base_code : (base_code | new_rows_ext);
            code0_next   = code_next;
        end

        if (emit_now)
        begin
            mvalid_next = 1'b1;
            ocode_next  = code_reg;
            ox_next     = x_reg;
            oy_next     = y_reg;
            ocolor_next = color_reg;
            omx_next    = fx_reg;
            omy_next    = fy_reg;
            olast_next  = row_end && col_end;
            if (row_end)
            begin
                row_next  = '0;
                col_next  = col_reg + SW'(1);
                x_next    = step_sum;
                y_next    = y0_reg;
                code_next = code0_reg;
                if (col_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            else
            begin
                row_next  = row_reg + SW'(1);
                y_next    = step_sum;
                code_next = code_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            rows_m1_reg <= '0;
            cols_m1_reg <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            y0_reg      <= '0;
            code_reg    <= '0;
            code0_reg   <= '0;
            color_reg   <= '0;
            fx_reg      <= 1'b0;
            fy_reg      <= 1'b0;
            mvalid_reg  <= 1'b0;
            ocode_reg   <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            ocolor_reg  <= '0;
            omx_reg     <= 1'b0;
            omy_reg     <= 1'b0;
            olast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            rows_m1_reg <= rows_m1_next;
            cols_m1_reg <= cols_m1_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            y0_reg      <= y0_next;
            code_reg    <= code_next;
            code0_reg   <= code0_next;
            color_reg   <= color_next;
            fx_reg      <= fx_next;
            fy_reg      <= fy_next;
            mvalid_reg  <= mvalid_next;
            ocode_reg   <= ocode_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            ocolor_reg  <= ocolor_next;
            omx_reg     <= omx_next;
            omy_reg     <= omy_next;
            olast_reg   <= olast_next;
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {1'b0, omy_reg, omx_reg, ocolor_reg, oy_reg, ox_reg, ocode_reg};

`ifndef NO_ASSERTIONS
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (row_reg <= rows_m1_reg))
        else $error("row counter beyond sprite height");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (col_reg <= cols_m1_reg))
        else $error("column counter beyond sprite width");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_now && row_end && col_end) |=> (state_reg == ST_IDLE && m_axis_tlast))
        else $error("final placement did not end the run");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("pending placement overwritten");
`endif

endmodule

// ===== test/sprite_tile_list_expander_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite tile list expander testbench
// Offers sprite entries on the input stream and checks every tile placement
// against one typed in the table or a local expansion of the entry. A short
// table of hand-picked entries covers the extremes and the suppressed cases,
// then random entries follow. Both streams stall at random, and the output is
// held off once for long enough to back the block up.
// ----------------------------------------------------------------------------
module sprite_tile_list_expander_top_test;

    localparam int RANDOM_ENTRIES = 441;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int DIR_ROWS       = 19;

    typedef struct packed {
        logic [stle_pkg::CODE_W-1:0]  code;
        logic [stle_pkg::COORD_W-1:0] x;
        logic [stle_pkg::COORD_W-1:0] y;
        logic [stle_pkg::COLOR_W-1:0] color;
        logic                         mx;
        logic                         my;
        logic                         last;
    } placement_t;

    // fixed: expectation typed in the row; silent: the entry yields nothing
    typedef struct packed {
        logic [stle_pkg::WORD_W-1:0] attr;
        logic [stle_pkg::WORD_W-1:0] code;
        logic [stle_pkg::WORD_W-1:0] pos;
        logic                        odd;
        logic                        fixed;
        logic                        silent;
        placement_t                  exp;
    } entry_row_t;

    localparam entry_row_t DIRECTED [DIR_ROWS] = '{
        // plain 1x1 at the origin
        '{16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0,
          '{13'h0000, 10'd240, 10'd232, 4'h0, 1'b0, 1'b0, 1'b1}},
        // disabled entries
        '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, '0},
        '{16'h7FFF, 16'hFFFF, 16'hF7FF, 1'b1, 1'b1, 1'b1, '0},
        // flashing entry: hidden on an even frame, shown on an odd one
        '{16'h8000, 16'h0001, 16'h0800, 1'b0, 1'b1, 1'b1, '0},
        '{16'h8000, 16'h0001, 16'h0800, 1'b1, 1'b1, 1'b0,
          '{13'h0001, 10'd240, 10'd232, 4'h0, 1'b0, 1'b0, 1'b1}},
        // both flips, y = -1, x = 255 mirrored to -15, top colour and code
        '{16'hE1FF, 16'hFFFF, 16'hF6FF, 1'b1, 1'b1, 1'b0,
          '{13'h1FFF, 10'h3F1, 10'd233, 4'hF, 1'b1, 1'b1, 1'b1}},
        // most negative positions
        '{16'h8100, 16'h1234, 16'h0100, 1'b0, 1'b1, 1'b0,
          '{13'h1234, 10'd496, 10'd488, 4'h0, 1'b0, 1'b0, 1'b1}},
        // most positive positions
        '{16'h80FF, 16'h0000, 16'h00FF, 1'b0, 1'b1, 1'b0,
          '{13'h0000, 10'h3F1, 10'h3E9, 4'h0, 1'b0, 1'b0, 1'b1}},
        // the rest go through the predictor
        '{16'h9E00, 16'h1FFF, 16'h5123, 1'b1, 1'b0, 1'b0, '0},
        '{16'hFE80, 16'hE00F, 16'hA8FF, 1'b1, 1'b0, 1'b0, '0},
        '{16'h8A10, 16'h0003, 16'h3040, 1'b0, 1'b0, 1'b0, '0},
        '{16'hC800, 16'h0009, 16'h1000, 1'b0, 1'b0, 1'b0, '0},
        '{16'hA200, 16'h000A, 16'h2000, 1'b0, 1'b0, 1'b0, '0},
        '{16'h9000, 16'h0016, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{16'h8400, 16'h0016, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{16'h9800, 16'h0007, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{16'hD000, 16'h0013, 16'h7000, 1'b0, 1'b0, 1'b0, '0},
        '{16'h87FF, 16'h0100, 16'h01FF, 1'b1, 1'b0, 1'b0, '0},
        '{16'h9FFF, 16'h0000, 16'h0FFF, 1'b1, 1'b0, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    placement_t placements_due [$];
    int         errors = 0;
    int         cycle_count = 0;
    int         hold_count = 0;
    bit         hold_armed = 1'b0;
    bit         calm = 1'b0;

    sprite_tile_list_expander_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("sprite_tile_list_expander_top_test: errors");
            $finish;
        end
    end

    // Expand one entry into its placements, columns outer, rows inner.
    // Returns the number of placements queued.
    function automatic int expand_entry(input logic [stle_pkg::WORD_W-1:0] attr,
                                        input logic [stle_pkg::WORD_W-1:0] code_w,
                                        input logic [stle_pkg::WORD_W-1:0] pos,
                                        input logic odd);
        int                          high;
        int                          wide;
        int                          xs;
        int                          ys;
        logic [stle_pkg::CODE_W-1:0] base;
        placement_t                  p;
        if (!attr[stle_pkg::ATTR_EN_BIT])
            return 0;
        if (pos[stle_pkg::POS_FLASH_BIT] && !odd)
            return 0;
        high = 1 << attr[stle_pkg::ATTR_LH_LSB +: 2];
        wide = 1 << attr[stle_pkg::ATTR_LW_LSB +: 2];
        xs = pos[stle_pkg::POSN_W-1:0];
        ys = attr[stle_pkg::POSN_W-1:0];
        if (xs >= 256)
            xs -= 512;
        if (ys >= 256)
            ys -= 512;
        xs = stle_pkg::X_MIRROR - xs;
        ys = stle_pkg::Y_MIRROR - ys;
        base = code_w[stle_pkg::CODE_W-1:0] & ~stle_pkg::CODE_W'(high - 1);
        for (int c = 0; c < wide; c++)
        begin
            for (int r = 0; r < high; r++)
            begin
                p.code  = attr[stle_pkg::ATTR_FY_BIT]
                          ? base + stle_pkg::CODE_W'(r)
                          : base + stle_pkg::CODE_W'(high - 1 - r);
                p.x     = stle_pkg::COORD_W'(xs - stle_pkg::TILE_PIX * c);
                p.y     = stle_pkg::COORD_W'(ys - stle_pkg::TILE_PIX * r);
                p.color = pos[stle_pkg::POS_COLOR_LSB +: stle_pkg::COLOR_W];
                p.mx    = attr[stle_pkg::ATTR_FX_BIT];
                p.my    = attr[stle_pkg::ATTR_FY_BIT];
                p.last  = (c == wide - 1) && (r == high - 1);
                placements_due.push_back(p);
            end
        end
        return wide * high;
    endfunction

    // Sizes lean small so the run stays short; 8 tiles on an axis is rare.
    function automatic logic [1:0] pick_span();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return 2'd0;
        else if (roll < 75)
            return 2'd1;
        else if (roll < 95)
            return 2'd2;
        return 2'd3;
    endfunction

    // Offer one entry and hold it until the transfer.
    task automatic offer_entry(input logic [stle_pkg::WORD_W-1:0] attr,
                               input logic [stle_pkg::WORD_W-1:0] code_w,
                               input logic [stle_pkg::WORD_W-1:0] pos,
                               input logic odd);
        while (!calm && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pos, code_w, attr};
        s_axis_tuser  <= odd;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_placement();
        placement_t want;
        if (placements_due.size() == 0)
        begin
            $display("%0t: placement expected none got %0h", $time, m_axis_tdata);
            errors++;
            return;
        end
        want = placements_due.pop_front();
        report_field("tile_code",  16'(want.code),  16'(m_axis_tdata[12:0]));
        report_field("tile_x",     16'(want.x),     16'(m_axis_tdata[22:13]));
        report_field("tile_y",     16'(want.y),     16'(m_axis_tdata[32:23]));
        report_field("tile_color", 16'(want.color), 16'(m_axis_tdata[36:33]));
        report_field("mirror_x",   16'(want.mx),    16'(m_axis_tdata[37]));
        report_field("mirror_y",   16'(want.my),    16'(m_axis_tdata[38]));
        report_field("last_tile",  16'(want.last),  16'(m_axis_tlast));
    endtask

    // Output side: check each transfer, then choose the next ready.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_placement();
        if (hold_armed && hold_count < HOLD_CYCLES)
        begin
            m_axis_tready <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 6);
    end

    initial
    begin
        int                          offered;
        logic [stle_pkg::WORD_W-1:0] attr;
        logic [stle_pkg::WORD_W-1:0] code_w;
        logic [stle_pkg::WORD_W-1:0] pos;
        logic                        odd;

        offered  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            offer_entry(DIRECTED[i].attr, DIRECTED[i].code, DIRECTED[i].pos, DIRECTED[i].odd);
            if (!DIRECTED[i].fixed)
                void'(expand_entry(DIRECTED[i].attr, DIRECTED[i].code,
                                   DIRECTED[i].pos, DIRECTED[i].odd));
            else if (!DIRECTED[i].silent)
                placements_due.push_back(DIRECTED[i].exp);
        end

        while (offered < RANDOM_ENTRIES)
        begin
            attr   = stle_pkg::WORD_W'($urandom);
            code_w = stle_pkg::WORD_W'($urandom);
            pos    = stle_pkg::WORD_W'($urandom);
            odd    = 1'($urandom_range(1));
            attr[stle_pkg::ATTR_EN_BIT] = $urandom_range(99) < 88;
            attr[stle_pkg::ATTR_LH_LSB +: 2] = pick_span();
            attr[stle_pkg::ATTR_LW_LSB +: 2] = pick_span();
            pos[stle_pkg::POS_FLASH_BIT] = $urandom_range(99) < 25;
            offer_entry(attr, code_w, pos, odd);
            void'(expand_entry(attr, code_w, pos, odd));
            offered++;
            // a stretch with no stalls on either side, then one long hold-off
            if (offered == 150)
                calm = 1'b1;
            if (offered == 260)
                calm = 1'b0;
            if (offered == 300)
                hold_armed = 1'b1;
        end
        s_axis_tvalid <= 1'b0;

        while (placements_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("sprite_tile_list_expander_top_test: clean");
        else
            $display("sprite_tile_list_expander_top_test: errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/stle_pkg.sv
design/sprite_tile_list_expander_top.sv
test/sprite_tile_list_expander_top_test.sv
